@@ rtl/psil_pkg.sv @@
`timescale 1ns / 1ps
// Package for the per-source ICMP limiter: frame classification constants
// and the token type that travels down the chain of table cells.
// No dependencies.
package psil_pkg;

  localparam int unsigned KeyWidth   = 32;
  localparam int unsigned CountWidth = 32;

  localparam logic [15:0] MIN_ETH_BYTES  = 16'd14;
  localparam logic [15:0] MIN_ICMP_BYTES = 16'd42;
  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_ICMP     = 8'd1;

  localparam logic [CountWidth-1:0] COUNT_MAX = {CountWidth{1'b1}};

  localparam logic VERDICT_PASS = 1'b0;
  localparam logic VERDICT_DROP = 1'b1;

  // One item in flight. search is set while an ICMP item still looks for
  // its source in the table; hit marks an item that matched a stored key.
  typedef struct packed {
    logic                  vld;
    logic                  search;
    logic                  hit;
    logic                  drop;
    logic [KeyWidth-1:0]   key;
    logic [CountWidth-1:0] count;
  } token_t;

endpackage

@@ rtl/psil_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces of the per-source ICMP limiter: header
// summaries in, verdicts out, and the threshold write channel. No dependencies.
interface psil_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] frame_length;
  logic [15:0] ether_type;
  logic [7:0]  ip_protocol;
  logic [31:0] source_address;

  modport source (output valid, frame_length, ether_type, ip_protocol,
                  source_address, input ready);
  modport sink (input valid, frame_length, ether_type, ip_protocol,
                source_address, output ready);
endinterface

interface psil_out_if;
  logic        valid;
  logic        ready;
  logic        verdict;
  logic [31:0] source_count;
  logic        table_full;

  modport source (output valid, verdict, source_count, table_full, input ready);
  modport sink (input valid, verdict, source_count, table_full, output ready);
endinterface

interface psil_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] drop_threshold;

  modport source (output valid, drop_threshold, input ready);
  modport sink (input valid, drop_threshold, output ready);
endinterface

@@ rtl/psil_cell.sv @@
`timescale 1ns / 1ps
// One table slot of the per-source ICMP limiter. It holds a key and a count,
// serves the token passing through it and hands it on. Depends on psil_pkg.
module psil_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  psil_pkg::token_t tok_i,
  output psil_pkg::token_t tok_o
);

  logic [psil_pkg::CountWidth-1:0] count_one;
  logic [psil_pkg::KeyWidth-1:0]   key_r,   key_nxt;
  logic [psil_pkg::CountWidth-1:0] count_r, count_nxt;
  logic                            valid_r, valid_nxt;
  psil_pkg::token_t                tok_r,   tok_nxt;

  logic                            hit;
  logic                            ins;
  logic [psil_pkg::CountWidth-1:0] count_inc;

  assign count_one = {{(psil_pkg::CountWidth-1){1'b0}}, 1'b1};

  assign hit = tok_i.vld && tok_i.search && valid_r && (key_r == tok_i.key);
  // Slots fill from the front, so the first empty slot a searching token
  // meets lies behind every stored key.
  assign ins = tok_i.vld && tok_i.search && !valid_r;
  assign count_inc = (count_r == psil_pkg::COUNT_MAX) ? count_r
                                                      : count_r + count_one;

  always_comb begin
    key_nxt   = key_r;
    count_nxt = count_r;
    valid_nxt = valid_r;
    tok_nxt   = tok_i;
    if (hit) begin
      count_nxt      = count_inc;
      tok_nxt.search = 1'b0;
      tok_nxt.hit    = 1'b1;
      tok_nxt.count  = count_inc;
    end else if (ins) begin
      key_nxt        = tok_i.key;
      count_nxt      = count_one;
      valid_nxt      = 1'b1;
      tok_nxt.search = 1'b0;
      tok_nxt.count  = count_one;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= 1'b0;
      tok_r.vld <= 1'b0;
    end else if (adv) begin
      key_r   <= key_nxt;
      count_r <= count_nxt;
      valid_r <= valid_nxt;
      tok_r   <= tok_nxt;
    end
  end

  assign tok_o = tok_r;

endmodule

@@ rtl/per_source_icmp_limiter.sv @@
`timescale 1ns / 1ps
// Top level of the per-source ICMP limiter: frame classification, the chain
// of table cells and the output register. Depends on psil_pkg, psil_if, psil_cell.
//
// Usage. Each item on in_chan is the header summary of one received frame.
// Runt frames and short IPv4 frames are marked for dropping, other non-ICMP
// frames pass, and ICMP frames are counted per IPv4 source address. Exactly
// one item leaves on out_chan for every item taken, in the same order.
// The table is a row of TABLE_DEPTH cells, one slot each. Every item walks
// down the row one cell per cycle: the cell holding its source increments
// the count, or the first empty cell takes the source in. Because items keep
// their order along the row, a later item always sees the updates made by
// earlier ones. An item that reaches the end still searching found the
// table full.
// Each result passes through every cell of the row and then the output
// register before it is valid. One item is taken per cycle while the
// receiver does not stall, set by the single-step shift of the cell row;
// a stalled result holds the whole row and in_chan.ready until it is taken.
// Reset empties every slot, drops all items in flight and sets the drop
// threshold to 5; cfg_chan writes a new threshold in any cycle.
module per_source_icmp_limiter #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  psil_in_if.sink    in_chan,
  psil_out_if.source out_chan,
  psil_cfg_if.sink   cfg_chan
);

  psil_pkg::token_t                head_tok;
  psil_pkg::token_t                chain [0:TABLE_DEPTH];
  psil_pkg::token_t                last_tok;
  logic                            adv;
  logic                            is_ipv4;
  logic [psil_pkg::CountWidth-1:0] thr_r;

  logic                            out_valid_r;
  logic                            verdict_r,    verdict_nxt;
  logic [psil_pkg::CountWidth-1:0] count_r,      count_nxt;
  logic                            full_r,       full_nxt;

  // The row moves whenever the output register is empty or being emptied.
  assign adv = !out_valid_r || out_chan.ready;
  assign in_chan.ready = adv;

  // Classify the frame on entry, so the cells only see the ICMP search flag.
  assign is_ipv4 = (in_chan.ether_type == psil_pkg::ETHERTYPE_IPV4);

  always_comb begin
    head_tok.vld    = in_chan.valid;
    head_tok.hit    = 1'b0;
    head_tok.key    = in_chan.source_address;
    head_tok.count  = '0;
    head_tok.drop   = (in_chan.frame_length < psil_pkg::MIN_ETH_BYTES) ||
                      (is_ipv4 && (in_chan.frame_length < psil_pkg::MIN_ICMP_BYTES));
    head_tok.search = is_ipv4 &&
                      (in_chan.frame_length >= psil_pkg::MIN_ICMP_BYTES) &&
                      (in_chan.ip_protocol == psil_pkg::PROTO_ICMP);
  end

  assign chain[0] = head_tok;

  for (genvar gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
    psil_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .tok_i (chain[gi]),
      .tok_o (chain[gi+1])
    );
  end

  assign last_tok = chain[TABLE_DEPTH];

  // A token still searching at the end of the row met no free slot: the
  // frame passes uncounted and the full flag is raised.
  always_comb begin
    full_nxt    = last_tok.search;
    count_nxt   = last_tok.search ? '0 : last_tok.count;
    verdict_nxt = (last_tok.drop || (last_tok.hit && (last_tok.count > thr_r)))
                  ? psil_pkg::VERDICT_DROP : psil_pkg::VERDICT_PASS;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= last_tok.vld;
      verdict_r   <= verdict_nxt;
      count_r     <= count_nxt;
      full_r      <= full_nxt;
    end
  end

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= 32'd5;
    end else if (cfg_chan.valid) begin
      thr_r <= cfg_chan.drop_threshold;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.verdict      = verdict_r;
  assign out_chan.source_count = count_r;
  assign out_chan.table_full   = full_r;

  // A result held back by the receiver must also hold back the input side.
  a_stall_blocks_input : assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && !out_chan.ready) |-> !in_chan.ready)
    else $error("input accepted while a result is stalled");

  // A frame that could not be inserted is never counted and never dropped.
  a_full_uncounted : assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.table_full) |->
      (out_chan.source_count == '0 && out_chan.verdict == psil_pkg::VERDICT_PASS))
    else $error("table-full result carries a count or a drop");

  // A counted frame at or below the threshold passes.
  a_threshold : assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.source_count != '0 &&
     out_chan.source_count <= thr_r) |-> (out_chan.verdict == psil_pkg::VERDICT_PASS))
    else $error("counted frame dropped at or below threshold");

endmodule
